// ===== hdl/ionce_pkg.sv =====
// ----------------------------------------------------------------------------
// ionce_pkg
// Shared types and constants of the ion chamber charge estimator.
// ----------------------------------------------------------------------------
package ionce_pkg;

  localparam int unsigned CHANNELS   = 5;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // square root pipeline: 32-bit radicand, two bits per step
  localparam int unsigned SQ_IN_W  = 32;
  localparam int unsigned SQ_OUT_W = 16;
  localparam int unsigned SQ_REM_W = 19;
  localparam int unsigned SQ_PER   = 4;
  localparam int unsigned SQ_ST    = 4;

  localparam logic [11:0] NOISE_THR_RST  = 12'd216;
  localparam logic [11:0] PILEUP_LIM_RST = 12'd1500;
  localparam logic [15:0] Z_GAIN_RST     = 16'd13763;
  localparam logic [15:0] Z_OFFSET_RST   = 16'd2345;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_THR  = 3'd0,
    CFG_PILEUP_LIM = 3'd1,
    CFG_Z_GAIN     = 3'd2,
    CFG_Z_OFFSET   = 3'd3,
    CFG_MUX_EXTRA  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_FIRED   = 3'd1,
    ST_ADC_PILEUP  = 3'd2,
    ST_SAMP_PILEUP = 3'd3,
    ST_NO_CHAN     = 3'd4,
    ST_NO_BETA     = 3'd5
  } status_e;

  typedef struct packed {
    logic [11:0] noise_thr;
    logic [11:0] pileup_lim;
    logic [15:0] z_gain;
    logic [15:0] z_offset;
    logic        mux_extra;
  } cfg_t;

  // sideband that travels with an event down the pipeline
  typedef struct packed {
    status_e     status;
    logic [15:0] beta;
    logic [15:0] energy;
    logic [12:0] pow;
    logic [28:0] m1;
    logic [42:0] m2;
    logic [15:0] charge;
  } side_t;

endpackage

// ===== hdl/ion_chamber_charge_estimator.sv =====
// ----------------------------------------------------------------------------
// ion_chamber_charge_estimator
// Per-event energy deposit average and charge estimate for an ion chamber.
// ----------------------------------------------------------------------------
// One event is taken per clock while the pipeline does not stall, and each
// gives one result beat. The pipeline is 8 + ceil((ADC_BITS + 7) / 4) stages
// deep: one stage of channel lanes and merge, the divider stages at four
// quotient bits each, one stage for saturation and the beta^0.8 table, four
// square root stages (the first also forms gain times beta^0.8), one
// multiplier stage and the output register. Stages advance independently, so
// bubbles close up while the output stalls.
module ion_chamber_charge_estimator #(
  parameter int unsigned ADC_BITS       = 12,
  parameter int unsigned POW_TABLE_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ionce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ionce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ADC_BITS-1:0]              chan_adc_a_i,
  input  logic [ADC_BITS-1:0]              chan_adc_b_i,
  input  logic [ADC_BITS-1:0]              chan_adc_c_i,
  input  logic [ADC_BITS-1:0]              chan_adc_d_i,
  input  logic [ADC_BITS-1:0]              chan_adc_e_i,
  input  logic [ionce_pkg::CHANNELS-1:0]   chan_fired_mask_i,
  input  logic [ADC_BITS-1:0]              pileup_adc_i,
  input  logic                             sampler_pileup_i,
  input  logic                             detector_fired_i,
  input  logic [15:0]                      beta_value_i,
  input  logic                             beta_valid_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [15:0]                      energy_loss_o,
  output logic                             energy_valid_o,
  output logic [15:0]                      charge_number_o,
  output logic                             charge_valid_o,
  output logic [2:0]                       status_code_o
);

  localparam int unsigned CH     = ionce_pkg::CHANNELS;
  localparam int unsigned CW     = ionce_pkg::CNT_W;
  localparam int unsigned SUM_W  = ADC_BITS + 3;
  localparam int unsigned N_W    = SUM_W + 4;
  localparam int unsigned DST    = (N_W + 3) / 4;
  localparam int unsigned E_ST   = DST + 1;
  localparam int unsigned SQ_END = E_ST + ionce_pkg::SQ_ST;
  localparam int unsigned M2_ST  = SQ_END + 1;
  localparam int unsigned NST    = SQ_END + 3;
  localparam int unsigned FB     = 16 - POW_TABLE_BITS;
  localparam int unsigned TBL_N  = (1 << POW_TABLE_BITS) + 1;

  // floor fifth root of i^4 * 2^(60 - 4*ptb), built bit by bit
  function automatic logic [12:0] pow_entry(input int unsigned i, input int unsigned ptb);
    logic [63:0] x;
    logic [63:0] ii;
    logic [63:0] t;
    logic [12:0] y;
    ii = 64'(i);
    x  = (ii * ii * ii * ii) << (60 - 4 * ptb);
    y  = '0;
    for (int b = 12; b >= 0; b--) begin
      t = 64'(y | (13'd1 << b));
      if (t * t * t * t * t <= x) begin
        y = 13'(t);
      end
    end
    return y;
  endfunction

  logic [12:0] pow_tbl [TBL_N];
  for (genvar g = 0; g < TBL_N; g++) begin : g_tbl
    assign pow_tbl[g] = pow_entry(g, POW_TABLE_BITS);
  end

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  ionce_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (ionce_pkg::cfg_idx_e'(cfg_index_i))
        ionce_pkg::CFG_NOISE_THR:  cfg_d.noise_thr  = cfg_data_i[11:0];
        ionce_pkg::CFG_PILEUP_LIM: cfg_d.pileup_lim = cfg_data_i[11:0];
        ionce_pkg::CFG_Z_GAIN:     cfg_d.z_gain     = cfg_data_i;
        ionce_pkg::CFG_Z_OFFSET:   cfg_d.z_offset   = cfg_data_i;
        ionce_pkg::CFG_MUX_EXTRA:  cfg_d.mux_extra  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_thr  <= ionce_pkg::NOISE_THR_RST;
      cfg_q.pileup_lim <= ionce_pkg::PILEUP_LIM_RST;
      cfg_q.z_gain     <= ionce_pkg::Z_GAIN_RST;
      cfg_q.z_offset   <= ionce_pkg::Z_OFFSET_RST;
      cfg_q.mux_extra  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // --------------------------------------------------------------------------
  // valid / ready chain
  // --------------------------------------------------------------------------
  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: channel lanes and merge
  // --------------------------------------------------------------------------
  logic [ADC_BITS-1:0] adc [CH];
  logic [ADC_BITS-1:0] val [CH];
  logic [CH-1:0]       hit;

  assign adc[0] = chan_adc_a_i;
  assign adc[1] = chan_adc_b_i;
  assign adc[2] = chan_adc_c_i;
  assign adc[3] = chan_adc_d_i;
  assign adc[4] = chan_adc_e_i;

  for (genvar g = 0; g < CH; g++) begin : g_lane
    ionce_lane #(
      .ADC_BITS(ADC_BITS)
    ) u_lane (
      .adc_i  (adc[g]),
      .fired_i(chan_fired_mask_i[g]),
      .thr_i  (cfg_q.noise_thr),
      .hit_o  (hit[g]),
      .val_o  (val[g])
    );
  end

  logic [SUM_W-1:0] sum_d, sum_q;
  logic [CW-1:0]    cnt_d, cnt_q;
  ionce_pkg::side_t s0;
  logic [16:0]      pile_x;
  logic [16:0]      lim_x;

  assign pile_x = 17'(pileup_adc_i);
  assign lim_x  = 17'(cfg_q.pileup_lim);

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int k = 0; k < CH; k++) begin
      sum_d = sum_d + SUM_W'(val[k]);
      cnt_d = cnt_d + CW'(hit[k]);
    end
    cnt_d = cnt_d + CW'(cfg_q.mux_extra && chan_fired_mask_i[CH-1]);

    s0        = '0;
    s0.beta   = beta_value_i;
    priority if (!detector_fired_i) begin
      s0.status = ionce_pkg::ST_NOT_FIRED;
    end else if (pile_x > lim_x) begin
      s0.status = ionce_pkg::ST_ADC_PILEUP;
    end else if (sampler_pileup_i) begin
      s0.status = ionce_pkg::ST_SAMP_PILEUP;
    end else if (cnt_d == '0) begin
      s0.status = ionce_pkg::ST_NO_CHAN;
    end else if (!beta_valid_i) begin
      s0.status = ionce_pkg::ST_NO_BETA;
    end else begin
      s0.status = ionce_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // divider: round(16 * sum / cnt)
  // --------------------------------------------------------------------------
  logic [N_W-1:0] div_n;
  logic [N_W-1:0] quot;

  assign div_n = {sum_q, 4'b0000} | N_W'(cnt_q >> 1);

  ionce_div #(
    .N_W   (N_W),
    .STAGES(DST)
  ) u_div (
    .clk_i(clk_i),
    .en_i (rdy[DST:1]),
    .n_i  (div_n),
    .d_i  (cnt_q),
    .q_o  (quot)
  );

  // --------------------------------------------------------------------------
  // sideband, with per-stage work on the fields that come due
  // --------------------------------------------------------------------------
  ionce_pkg::side_t side_q [NST];
  ionce_pkg::side_t side_d [NST];

  logic [31:0]               quot_x;
  logic [POW_TABLE_BITS-1:0] t_idx;
  logic [POW_TABLE_BITS:0]   t_nxt;
  logic [FB-1:0]             t_frac;
  logic [12:0]               t0;
  logic [12:0]               t1;
  logic [12+FB:0]            t_prod;
  logic [15:0]               root;
  logic [42:0]               z_rnd;
  logic [19:0]               z_sum;
  logic                      ok_f;
  logic                      e_ok_f;

  assign quot_x = 32'(quot);
  assign t_idx  = side_q[DST].beta[15:FB];
  assign t_nxt  = {1'b0, t_idx} + 1'b1;
  assign t_frac = side_q[DST].beta[FB-1:0];
  assign t0     = pow_tbl[t_idx];
  assign t1     = pow_tbl[t_nxt];
  assign t_prod = (t1 - t0) * t_frac;

  ionce_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (rdy[SQ_END:E_ST+1]),
    .v_i   ({4'b0000, side_q[E_ST].energy, 12'b0}),
    .root_o(root)
  );

  assign ok_f   = side_q[NST-2].status == ionce_pkg::ST_OK;
  assign e_ok_f = ok_f || (side_q[NST-2].status == ionce_pkg::ST_NO_BETA);
  assign z_rnd  = (side_q[M2_ST].m2 + 43'(1 << 24)) >> 25;
  assign z_sum  = 20'(z_rnd) + 20'(cfg_q.z_offset);

  always_comb begin
    side_d[0] = s0;
    for (int k = 1; k < NST; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[E_ST].energy = (quot_x > 32'h0000_FFFF) ? 16'hFFFF : quot_x[15:0];
    side_d[E_ST].pow    = t0 + 13'(t_prod >> FB);
    side_d[E_ST+1].m1   = 29'(side_q[E_ST].pow) * 29'(cfg_q.z_gain);
    side_d[M2_ST].m2    = 43'(side_q[SQ_END].m1) * 43'(root);
    // drop fields that the status does not validate
    side_d[NST-1].charge = !ok_f ? 16'h0000 :
                           (z_sum > 20'h0FFFF) ? 16'hFFFF : z_sum[15:0];
    side_d[NST-1].energy = e_ok_f ? side_q[NST-2].energy : 16'h0000;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // result beat
  // --------------------------------------------------------------------------
  assign out_valid_o     = v_q[NST-1];
  assign status_code_o   = side_q[NST-1].status;
  assign energy_loss_o   = side_q[NST-1].energy;
  assign charge_number_o = side_q[NST-1].charge;
  assign charge_valid_o  = side_q[NST-1].status == ionce_pkg::ST_OK;
  assign energy_valid_o  = charge_valid_o || (side_q[NST-1].status == ionce_pkg::ST_NO_BETA);

endmodule

// ===== hdl/ionce_lane.sv =====
// ----------------------------------------------------------------------------
// ionce_lane
// One channel lane: qualify an ADC value against fired flag and threshold.
// ----------------------------------------------------------------------------
module ionce_lane #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic [ADC_BITS-1:0] adc_i,
  input  logic                fired_i,
  input  logic [11:0]         thr_i,
  output logic                hit_o,
  output logic [ADC_BITS-1:0] val_o
);

  logic [16:0] adc_x;
  logic [16:0] thr_x;

  assign adc_x = 17'(adc_i);
  assign thr_x = 17'(thr_i);
  assign hit_o = fired_i && (adc_x >= thr_x);
  assign val_o = hit_o ? adc_i : '0;

endmodule

// ===== hdl/ionce_div.sv =====
// ----------------------------------------------------------------------------
// ionce_div
// Pipelined restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
module ionce_div #(
  parameter int unsigned N_W    = 19,
  parameter int unsigned STAGES = 5
) (
  input  logic                        clk_i,
  input  logic [STAGES-1:0]           en_i,
  input  logic [N_W-1:0]              n_i,
  input  logic [ionce_pkg::CNT_W-1:0] d_i,
  output logic [N_W-1:0]              q_o
);

  localparam int unsigned PER = 4;
  localparam int unsigned PW  = STAGES * PER;
  localparam int unsigned DW  = ionce_pkg::CNT_W;

  logic [PW-1:0] n_q [STAGES];
  logic [PW-1:0] q_q [STAGES];
  logic [DW:0]   r_q [STAGES];
  logic [DW-1:0] d_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_st
    logic [PW-1:0] n_in;
    logic [PW-1:0] q_in;
    logic [DW:0]   r_in;
    logic [DW-1:0] d_in;
    logic [PW-1:0] n_d;
    logic [PW-1:0] q_d;
    logic [DW:0]   r_d;

    if (g == 0) begin : g_first
      assign n_in = PW'(n_i);
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = d_i;
    end else begin : g_next
      assign n_in = n_q[g-1];
      assign q_in = q_q[g-1];
      assign r_in = r_q[g-1];
      assign d_in = d_q[g-1];
    end

    always_comb begin
      n_d = n_in;
      q_d = q_in;
      r_d = r_in;
      for (int j = 0; j < PER; j++) begin
        r_d = {r_d[DW-1:0], n_d[PW-1]};
        n_d = {n_d[PW-2:0], 1'b0};
        if (r_d >= {1'b0, d_in}) begin
          r_d = r_d - {1'b0, d_in};
          q_d = {q_d[PW-2:0], 1'b1};
        end else begin
          q_d = {q_d[PW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[g]) begin
        n_q[g] <= n_d;
        q_q[g] <= q_d;
        r_q[g] <= r_d;
        d_q[g] <= d_in;
      end
    end
  end

  assign q_o = q_q[STAGES-1][N_W-1:0];

endmodule

// ===== hdl/ionce_sqrt.sv =====
// ----------------------------------------------------------------------------
// ionce_sqrt
// Pipelined digit-by-digit integer square root, four root bits per stage.
// ----------------------------------------------------------------------------
module ionce_sqrt (
  input  logic                           clk_i,
  input  logic [ionce_pkg::SQ_ST-1:0]    en_i,
  input  logic [ionce_pkg::SQ_IN_W-1:0]  v_i,
  output logic [ionce_pkg::SQ_OUT_W-1:0] root_o
);

  localparam int unsigned IW = ionce_pkg::SQ_IN_W;
  localparam int unsigned OW = ionce_pkg::SQ_OUT_W;
  localparam int unsigned RW = ionce_pkg::SQ_REM_W;
  localparam int unsigned ST = ionce_pkg::SQ_ST;

  logic [IW-1:0] v_q    [ST];
  logic [OW-1:0] root_q [ST];
  logic [RW-1:0] rem_q  [ST];

  for (genvar g = 0; g < ST; g++) begin : g_st
    logic [IW-1:0] v_in;
    logic [OW-1:0] root_in;
    logic [RW-1:0] rem_in;
    logic [IW-1:0] v_d;
    logic [OW-1:0] root_d;
    logic [RW-1:0] rem_d;
    logic [RW-1:0] trial;

    if (g == 0) begin : g_first
      assign v_in    = v_i;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign root_in = root_q[g-1];
      assign rem_in  = rem_q[g-1];
    end

    always_comb begin
      v_d    = v_in;
      root_d = root_in;
      rem_d  = rem_in;
      trial  = '0;
      for (int j = 0; j < ionce_pkg::SQ_PER; j++) begin
        rem_d = {rem_d[RW-3:0], v_d[IW-1:IW-2]};
        v_d   = {v_d[IW-3:0], 2'b00};
        trial = RW'({root_d, 2'b01});
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[OW-2:0], 1'b1};
        end else begin
          root_d = {root_d[OW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[g]) begin
        v_q[g]    <= v_d;
        root_q[g] <= root_d;
        rem_q[g]  <= rem_d;
      end
    end
  end

  assign root_o = root_q[ST-1];

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ion chamber charge estimator: events are
// predicted in-bench, results checked field by field in order, under
// several register settings and random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [11:0] adc [5];
    logic [4:0]  mask;
    logic [11:0] pile;
    logic        samp;
    logic        fired;
    logic [15:0] beta;
    logic        bvalid;
  } event_t;

  typedef struct {
    logic [15:0]        energy;
    logic               e_valid;
    logic [15:0]        charge;
    logic               c_valid;
    ionce_pkg::status_e status;
  } charge_res_t;

  localparam int LIMIT_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ionce_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ionce_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [11:0] chan_adc_a_i = '0, chan_adc_b_i = '0, chan_adc_c_i = '0;
  logic [11:0] chan_adc_d_i = '0, chan_adc_e_i = '0;
  logic [4:0] chan_fired_mask_i = '0;
  logic [11:0] pileup_adc_i = '0;
  logic sampler_pileup_i = 1'b0, detector_fired_i = 1'b0;
  logic [15:0] beta_value_i = '0;
  logic beta_valid_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] energy_loss_o, charge_number_o;
  logic energy_valid_o, charge_valid_o;
  logic [2:0] status_code_o;

  ion_chamber_charge_estimator dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // register shadow
  logic [11:0] noise_thr, pileup_lim;
  logic [15:0] gain, offset;
  logic        mux_extra;

  logic [12:0] pow_tab [257];
  charge_res_t expected_q [$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic logic [12:0] fifth_root_entry(int unsigned i);
    longint unsigned x, lo, hi, mid;
    x = (longint'(i) * i * i * i) << (60 - 4 * 8);
    lo = 0;
    hi = 4096;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * mid * mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo[12:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
    end
    return r;
  endfunction

  function automatic charge_res_t predict_charge(event_t ev);
    charge_res_t res;
    longint unsigned sum, cnt, e, p, s, z, t0, t1;
    res = '{16'd0, 1'b0, 16'd0, 1'b0, ionce_pkg::ST_OK};
    sum = 0;
    cnt = 0;
    if (!ev.fired) res.status = ionce_pkg::ST_NOT_FIRED;
    else if (ev.pile > pileup_lim) res.status = ionce_pkg::ST_ADC_PILEUP;
    else if (ev.samp) res.status = ionce_pkg::ST_SAMP_PILEUP;
    if (res.status == ionce_pkg::ST_OK) begin
      for (int k = 0; k < 5; k++) begin
        if (ev.mask[k] && ev.adc[k] >= noise_thr) begin
          sum += ev.adc[k];
          cnt++;
        end
      end
      if (mux_extra && ev.mask[4]) cnt++;
      if (cnt == 0) res.status = ionce_pkg::ST_NO_CHAN;
    end
    if (res.status == ionce_pkg::ST_OK) begin
      e = (sum * 16 + cnt / 2) / cnt;
      if (e > 65535) e = 65535;
      res.energy = e[15:0];
      res.e_valid = 1'b1;
      if (!ev.bvalid) begin
        res.status = ionce_pkg::ST_NO_BETA;
      end else begin
        t0 = pow_tab[ev.beta[15:8]];
        t1 = pow_tab[ev.beta[15:8] + 1];
        p = t0 + (((t1 - t0) * ev.beta[7:0]) >> 8);
        s = int_sqrt(e << 12);
        z = ((gain * p * s + (64'd1 << 24)) >> 25) + offset;
        if (z > 65535) z = 65535;
        res.charge = z[15:0];
        res.c_valid = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic write_reg(ionce_pkg::cfg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ionce_pkg::CFG_NOISE_THR:  noise_thr = data[11:0];
      ionce_pkg::CFG_PILEUP_LIM: pileup_lim = data[11:0];
      ionce_pkg::CFG_Z_GAIN:     gain = data;
      ionce_pkg::CFG_Z_OFFSET:   offset = data;
      ionce_pkg::CFG_MUX_EXTRA:  mux_extra = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_regs(logic [11:0] thr, logic [11:0] lim, logic [15:0] g,
                          logic [15:0] o, logic mx);
    write_reg(ionce_pkg::CFG_NOISE_THR, {4'd0, thr});
    write_reg(ionce_pkg::CFG_PILEUP_LIM, {4'd0, lim});
    write_reg(ionce_pkg::CFG_Z_GAIN, g);
    write_reg(ionce_pkg::CFG_Z_OFFSET, o);
    write_reg(ionce_pkg::CFG_MUX_EXTRA, {15'd0, mx});
  endtask

  // hold the beat until accepted, then maybe drop valid for a gap
  task automatic send_event(event_t ev);
    chan_adc_a_i = ev.adc[0];
    chan_adc_b_i = ev.adc[1];
    chan_adc_c_i = ev.adc[2];
    chan_adc_d_i = ev.adc[3];
    chan_adc_e_i = ev.adc[4];
    chan_fired_mask_i = ev.mask;
    pileup_adc_i = ev.pile;
    sampler_pileup_i = ev.samp;
    detector_fired_i = ev.fired;
    beta_value_i = ev.beta;
    beta_valid_i = ev.bvalid;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.insert(expected_q.size(), predict_charge(ev));
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
  endtask

  // let the pipeline empty before touching registers
  task automatic drain;
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic event_t make_event(logic [11:0] a, logic [11:0] b, logic [11:0] c,
                                        logic [11:0] d, logic [11:0] e, logic [4:0] m,
                                        logic [11:0] pl, logic sp, logic fd,
                                        logic [15:0] bt, logic bv);
    event_t ev;
    ev.adc = '{a, b, c, d, e};
    ev.mask = m;
    ev.pile = pl;
    ev.samp = sp;
    ev.fired = fd;
    ev.beta = bt;
    ev.bvalid = bv;
    return ev;
  endfunction

  function automatic logic [11:0] rand_adc();
    case ($urandom_range(3))
      0: return 12'($urandom_range(4095));
      1: return 12'($urandom_range(noise_thr + 2, noise_thr > 1 ? noise_thr - 2 : 0));
      default: return 12'($urandom_range(4095, noise_thr));
    endcase
  endfunction

  task automatic test_directed;
    send_event(make_event(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(make_event(4095, 4095, 4095, 4095, 4095, 31, 4095, 1, 0, 16'hFFFF, 1));
    send_event(make_event(500, 500, 500, 500, 500, 31, 1501, 0, 1, 30000, 1));
    send_event(make_event(500, 500, 500, 500, 500, 31, 1500, 0, 1, 30000, 1));
    send_event(make_event(500, 500, 500, 500, 500, 31, 0, 1, 1, 30000, 1));
    send_event(make_event(4095, 4095, 4095, 4095, 4095, 0, 0, 0, 1, 30000, 1));
    send_event(make_event(100, 100, 100, 100, 100, 31, 0, 0, 1, 30000, 1));
    send_event(make_event(0, 0, 0, 0, 10, 5'b10000, 0, 0, 1, 30000, 1));
    send_event(make_event(216, 215, 216, 215, 216, 31, 0, 0, 1, 30000, 1));
    send_event(make_event(4095, 4095, 4095, 4095, 4095, 31, 0, 0, 1, 16'hFFFF, 1));
    send_event(make_event(4095, 4095, 4095, 4095, 4095, 31, 0, 0, 1, 16'hFFFF, 0));
    send_event(make_event(800, 900, 1000, 1100, 1200, 31, 0, 0, 1, 0, 1));
    send_event(make_event(800, 900, 1000, 1100, 1200, 5'b01111, 0, 0, 1, 255, 1));
    send_event(make_event(800, 0, 0, 0, 0, 5'b00001, 0, 0, 1, 256, 1));
    send_event(make_event(0, 0, 0, 0, 4095, 5'b10000, 0, 0, 1, 16'hAAAA, 1));
    send_event(make_event(0, 0, 0, 0, 4095, 5'b10000, 0, 0, 1, 16'h5555, 1));
  endtask

  // mostly clean events with random content, some rejected ones
  task automatic test_random(int n);
    event_t ev;
    for (int i = 0; i < n; i++) begin
      foreach (ev.adc[k]) ev.adc[k] = rand_adc();
      ev.mask = 5'($urandom_range(31));
      ev.fired = $urandom_range(19) != 0;
      ev.pile = $urandom_range(9) == 0 ? 12'($urandom_range(4095))
                                      : 12'($urandom_range(pileup_lim));
      ev.samp = $urandom_range(14) == 0;
      ev.beta = 16'($urandom_range(65535));
      ev.bvalid = $urandom_range(14) != 0;
      send_event(ev);
    end
  endtask

  always @(negedge clk_i) out_stall_i <= $urandom_range(99) < recv_idle_pct;

  always @(posedge clk_i) begin
    charge_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, status %0d", status_code_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (energy_loss_o !== exp_r.energy || energy_valid_o !== exp_r.e_valid ||
            charge_number_o !== exp_r.charge || charge_valid_o !== exp_r.c_valid ||
            status_code_o !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp e=%0d ev=%0b z=%0d zv=%0b st=%0d,",
                      " got e=%0d ev=%0b z=%0d zv=%0b st=%0d"},
                     exp_r.energy, exp_r.e_valid, exp_r.charge, exp_r.c_valid, exp_r.status,
                     energy_loss_o, energy_valid_o, charge_number_o, charge_valid_o,
                     status_code_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("ion_chamber_charge_estimator test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i <= 256; i++) pow_tab[i] = fifth_root_entry(i);
    noise_thr = ionce_pkg::NOISE_THR_RST;
    pileup_lim = ionce_pkg::PILEUP_LIM_RST;
    gain = ionce_pkg::Z_GAIN_RST;
    offset = ionce_pkg::Z_OFFSET_RST;
    mux_extra = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(negedge clk_i);

    send_idle_pct = 30;
    recv_idle_pct = 62;
    test_directed();
    test_random(500);
    drain();

    set_regs(12'd0, 12'd4095, 16'hFFFF, 16'hFFFF, 1'b0);
    send_idle_pct = 62;
    recv_idle_pct = 30;
    test_random(250);
    drain();
    set_regs(12'd4095, 12'd0, 16'd0, 16'd0, 1'b1);
    test_random(100);
    drain();

    set_regs(12'($urandom_range(1000)), 12'($urandom_range(4095, 2000)),
             16'($urandom_range(65535)), 16'($urandom_range(8000)), 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    drain();
    set_regs(12'd300, 12'd3000, 16'd40000, 16'd1000, 1'b1);
    test_random(350);
    drain();

    if (mismatches == 0) $display("ion_chamber_charge_estimator test passed");
    else $display("ion_chamber_charge_estimator test failed");
    $finish;
  end
endmodule
